// ----- hw/rtl/fds_pkg.sv -----
`timescale 1ns / 1ps
package fds_pkg;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;
    localparam int AMOUNT_W   = 32;
    localparam int FRAME_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int TOTAL_W    = 40;   // sum of up to 256 delays of 32 bits
    localparam int MEM_ADDR_W = 16;   // widest table address the block supports

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_LOAD    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_MOD,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_RESULT
    } seq_state_t;

    typedef struct packed {
        logic                  we;
        logic [MEM_ADDR_W-1:0] waddr;
        logic [AMOUNT_W-1:0]   wdata;
        logic [MEM_ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic                start;
        logic [AMOUNT_W-1:0] dividend;
        logic [TOTAL_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [AMOUNT_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ----- hw/rtl/fds_delay_mem.sv -----
`timescale 1ns / 1ps
module fds_delay_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                       aclk,
    input  fds_pkg::mem_req_t          mem_req,
    output logic [fds_pkg::AMOUNT_W-1:0] rdata
);
    import fds_pkg::*;

    logic [AMOUNT_W-1:0] mem [DEPTH];
    logic [AMOUNT_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
        end
        rdata_reg <= mem[mem_req.raddr[AW-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/fds_mod_unit.sv -----
`timescale 1ns / 1ps
module fds_mod_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  fds_pkg::div_req_t div_req,
    output fds_pkg::div_rsp_t div_rsp
);
    import fds_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [TOTAL_W-1:0]  rem_reg, rem_next;
    logic [AMOUNT_W-1:0] dvd_reg, dvd_next;
    logic [TOTAL_W-1:0]  dvs_reg, dvs_next;
    logic [TOTAL_W:0]    shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, dvd_reg[AMOUNT_W-1]};
        if (div_req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = div_req.dividend;
            dvs_next  = div_req.divisor;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = TOTAL_W'(shifted - {1'b0, dvs_reg});
            end else begin
                rem_next = shifted[TOTAL_W-1:0];
            end
            dvd_next = {dvd_reg[AMOUNT_W-2:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign div_rsp.done      = done_reg;
    assign div_rsp.remainder = rem_reg[AMOUNT_W-1:0];

endmodule

// ----- hw/rtl/fds_seq_ctrl.sv -----
`timescale 1ns / 1ps
module fds_seq_ctrl #(
    parameter int FRAMES_MAX = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fds_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fds_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [fds_pkg::COUNT_W-1:0]   frames_used,
    output fds_pkg::mem_req_t             mem_req,
    input  logic [fds_pkg::AMOUNT_W-1:0]  mem_rdata,
    output fds_pkg::div_req_t             div_req,
    input  fds_pkg::div_rsp_t             div_rsp
);
    import fds_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [AMOUNT_W-1:0] elapsed_reg, elapsed_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                acc_vld_reg, acc_vld_next;
    logic                changed_reg, changed_next;
    logic                stuck_reg, stuck_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    op_t                 in_op;
    logic [FRAME_W-1:0]  in_idx;
    logic [AMOUNT_W-1:0] in_amount;
    logic [COUNT_W-1:0]  frame_inc;
    logic                accept;
    logic                slot_free;

    assign in_op     = op_t'(s_tdata[1:0]);
    assign in_idx    = s_tdata[9:2];
    assign in_amount = s_tdata[41:10];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign frame_inc = {1'b0, frame_reg} + COUNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            elapsed_reg  <= '0;
            frame_reg    <= '0;
            cnt_reg      <= '0;
            acc_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            elapsed_reg  <= elapsed_next;
            frame_reg    <= frame_next;
            cnt_reg      <= cnt_next;
            acc_vld_reg  <= acc_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        total_reg   <= total_next;
        changed_reg <= changed_next;
        stuck_reg   <= stuck_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        elapsed_next  = elapsed_reg;
        frame_next    = frame_reg;
        total_next    = total_reg;
        cnt_next      = cnt_reg;
        acc_vld_next  = 1'b0;
        changed_next  = changed_reg;
        stuck_next    = stuck_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = MEM_ADDR_W'(in_idx);
        mem_req.wdata = in_amount;
        mem_req.raddr = MEM_ADDR_W'(frame_reg);

        div_req.start    = 1'b0;
        div_req.dividend = elapsed_reg;
        div_req.divisor  = total_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    changed_next = 1'b0;
                    stuck_next   = 1'b0;
                    state_next   = ST_RESULT;
                    case (in_op)
                        OP_LOAD: begin
                            mem_req.we = (32'(in_idx) < FRAMES_MAX);
                        end
                        OP_RESTART: begin
                            frame_next   = '0;
                            elapsed_next = '0;
                        end
                        OP_TICK: begin
                            if ({1'b0, frame_reg} >= frames_used) begin
                                frame_next = '0;
                            end
                            elapsed_next = elapsed_reg + in_amount;
                            total_next   = '0;
                            cnt_next     = '0;
                            state_next   = ST_SUM;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SUM: begin
                // stream the table in, one read issued per cycle
                mem_req.raddr = MEM_ADDR_W'(cnt_reg);
                if (cnt_reg < frames_used) begin
                    cnt_next     = cnt_reg + COUNT_W'(1);
                    acc_vld_next = 1'b1;
                end
                if (acc_vld_reg) begin
                    total_next = total_reg + TOTAL_W'(mem_rdata);
                end
                if (cnt_reg >= frames_used && !acc_vld_reg) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (total_reg == '0) begin
                    stuck_next = 1'b1;
                    state_next = ST_RESULT;
                end else if (TOTAL_W'(elapsed_reg) >= total_reg) begin
                    // drop whole passes over the table at once
                    div_req.start = 1'b1;
                    changed_next  = 1'b1;
                    state_next    = ST_MOD;
                end else begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_MOD: begin
                if (div_rsp.done) begin
                    elapsed_next = div_rsp.remainder;
                    state_next   = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                state_next = ST_WALK_CMP;
            end
            ST_WALK_CMP: begin
                if (elapsed_reg >= mem_rdata) begin
                    elapsed_next = elapsed_reg - mem_rdata;
                    changed_next = 1'b1;
                    if (frame_inc >= frames_used) begin
                        frame_next = '0;
                    end else begin
                        frame_next = frame_inc[FRAME_W-1:0];
                    end
                    state_next = ST_WALK_RD;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, stuck_reg, changed_reg, frame_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hw/rtl/frame_delay_sequencer.sv -----
`timescale 1ns / 1ps
// Load, restart and unused ops go to the result state, which registers the result once the
// output slot is free. A tick sums the delays of the frames in use, drops whole passes with a
// bit-serial remainder when elapsed time spans them, then advances frames with a table read,
// compare and subtract for each, before the result state. One transaction in work at a time.
// Synchronous active-low reset clears control, elapsed time and frame, and sets the frame
// count to 1; the delay table is not cleared and holds garbage until loaded.
module frame_delay_sequencer #(
    parameter int FRAMES_MAX = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,     // frame_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // op[1:0], entry_index[9:2], amount[41:10], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // frame[7:0], changed[8], stuck[9], zero
);
    import fds_pkg::*;

    localparam int MEM_AW = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
    localparam int N_LIM  = (FRAMES_MAX < 256) ? FRAMES_MAX : 256;
    localparam logic [COUNT_W-1:0] N_LIM_W = COUNT_W'(N_LIM);

    logic [COUNT_W-1:0]  frame_count_reg;
    logic [COUNT_W-1:0]  frames_used;
    mem_req_t            mem_req;
    logic [AMOUNT_W-1:0] mem_rdata;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= COUNT_W'(1);
        end else if (cfg_we) begin
            frame_count_reg <= cfg_wdata;
        end
    end

    // zero acts as one; clamp to the table size
    always_comb begin
        if (frame_count_reg == '0) begin
            frames_used = COUNT_W'(1);
        end else if (frame_count_reg > N_LIM_W) begin
            frames_used = N_LIM_W;
        end else begin
            frames_used = frame_count_reg;
        end
    end

    fds_seq_ctrl #(
        .FRAMES_MAX(FRAMES_MAX)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .frames_used (frames_used),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .div_req     (div_req),
        .div_rsp     (div_rsp)
    );

    fds_delay_mem #(
        .DEPTH(FRAMES_MAX),
        .AW   (MEM_AW)
    ) u_mem (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rdata   (mem_rdata)
    );

    fds_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

endmodule
